>>> hw/rtl/room_heat_balance_step_unit_defines.svh
// Assertion macros for the room heat balance step unit.
// Included by the top level; the macros expect clk and rst_n in scope.
`ifndef ROOM_HEAT_BALANCE_STEP_UNIT_DEFINES_SVH
`define ROOM_HEAT_BALANCE_STEP_UNIT_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, checked on every clock edge outside reset
`define RHBS_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rhbs: same-cycle property violated");

// Next-cycle implication
`define RHBS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rhbs: next-cycle property violated");

`else

`define RHBS_ASSERT_IMPLIES(lbl, ante, cons)
`define RHBS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> hw/rtl/rhbs_pkg.sv
// Shared constants, types and sequencer states of the room heat balance step unit.
// No dependencies; imported by every module of the block.
package rhbs_pkg;

    // Field widths
    localparam int DRIVE_W = 8;
    localparam int PCT_W   = 7;
    localparam int CFG_W   = 15;
    localparam int TEMP_W  = 16;
    localparam int OUT_W   = 40;
    localparam int ADDR_W  = 1;

    // Temperature in Kelvin as Q12.32 for the arithmetic
    localparam int XW = 44;
    localparam int FRAC_BITS_DEF = 24;

    // Register indexes of the configuration port
    localparam logic [ADDR_W-1:0] REG_OUTSIDE_TEMP = 1'd0;
    localparam logic [ADDR_W-1:0] REG_SETPOINT     = 1'd1;
    localparam logic [CFG_W-1:0]  CFG_RESET        = 15'd2560;

    // Model constants (fixed point)
    localparam logic [63:0] KELVIN_Q32 = 64'd1173170316902;  // 273.15 K
    localparam logic [63:0] RESET_Q32  = 64'd1216119989862;  // 283.15 K
    localparam logic [63:0] CH_Q32     = 64'd5875878;        // heater gain per percent
    localparam logic [63:0] C1_Q32     = 64'd1410211;        // conduction coefficient
    localparam logic [63:0] CR_Q80     = 64'd64711840400000; // radiation coefficient
    localparam logic [XW-1:0] X_MAX    = '1;

    // Sequencer states of the core
    typedef enum logic [3:0] {
        CORE_IDLE,
        CORE_HEAT,
        CORE_SQ_X,
        CORE_QUAD_X,
        CORE_SQ_O,
        CORE_QUAD_O,
        CORE_RAD,
        CORE_COND,
        CORE_SUM,
        CORE_SAT,
        CORE_REPORT,
        CORE_DONE
    } core_state_t;

    // Status the core reports to the stream wrapper
    typedef struct packed {
        logic busy;
        logic result_valid;
    } core_status_t;

endpackage

>>> hw/rtl/room_heat_balance_step_unit.sv
// Top level of the room heat balance step unit: stream ports, configuration
// registers and output register. Uses rhbs_pkg, rhbs_core and the assertion macros.
`include "room_heat_balance_step_unit_defines.svh"

// Each input item is one simulation tick with a heater drive percentage. The
// unit clamps it to 0..100, advances the room temperature (Kelvin, Q12.FRAC_BITS)
// by one Euler step of a lumped heat balance with heater, wall conduction and
// radiation, and returns the new temperature in 1/256 degree Celsius together
// with the applied percentage and the setpoint. From acceptance to result, seven
// wide products of an item go through one shared 32x32 multiplier, four partial
// products each, and s_tready stays low meanwhile. A finished result waits in
// the output register, so the next item is accepted while it is still pending.
// Registers: index 0 is the outside temperature, index 1 the setpoint, both 1/256
// degree Celsius, reset to 10 degrees; write them only while the unit is idle.
module room_heat_balance_step_unit #(
    parameter int FRAC_BITS = rhbs_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // Input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [rhbs_pkg::DRIVE_W-1:0] s_tdata,   // [7:0] drive_percent
    // Output stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [rhbs_pkg::OUT_W-1:0]   m_tdata,   // [15:0] room_temp_c,
                                                    // [22:16] applied_percent,
                                                    // [37:23] setpoint_echo
    // Configuration writes
    input  logic                         cfg_we,
    input  logic [rhbs_pkg::ADDR_W-1:0]  cfg_addr,
    input  logic [rhbs_pkg::CFG_W-1:0]   cfg_wdata
);
    import rhbs_pkg::*;

    logic [CFG_W-1:0]  outside_reg;
    logic [CFG_W-1:0]  setpoint_reg;
    logic [PCT_W-1:0]  applied_reg;
    logic              out_valid_reg;
    logic [TEMP_W-1:0] out_temp_reg;
    logic [PCT_W-1:0]  out_pct_reg;
    logic [CFG_W-1:0]  out_setpoint_reg;

    logic              in_accept;
    logic [PCT_W-1:0]  pct_clamped;
    logic              result_take;
    logic [TEMP_W-1:0] core_temp_c;
    core_status_t      core_status;

    // Accept a tick only while the core is idle
    assign s_tready  = !core_status.busy;
    assign in_accept = s_tvalid && s_tready;

    // Clamp the requested drive to 0..100
    always_comb
    begin
        if (s_tdata[DRIVE_W-1])
        begin
            pct_clamped = '0;
        end
        else if (s_tdata > 8'd100)
        begin
            pct_clamped = 7'd100;
        end
        else
        begin
            pct_clamped = s_tdata[PCT_W-1:0];
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outside_reg  <= CFG_RESET;
            setpoint_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_OUTSIDE_TEMP: outside_reg  <= cfg_wdata;
                REG_SETPOINT:     setpoint_reg <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    rhbs_core #(
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (in_accept),
        .pct         (pct_clamped),
        .outside_c   (outside_reg),
        .result_take (result_take),
        .status      (core_status),
        .room_temp_c (core_temp_c)
    );

    // Move a finished result into the output register when it is free
    assign result_take = core_status.result_valid && (!out_valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (result_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Hold the applied percentage and the result payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            applied_reg <= pct_clamped;
        end
        if (result_take)
        begin
            out_temp_reg     <= core_temp_c;
            out_pct_reg      <= applied_reg;
            out_setpoint_reg <= setpoint_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_setpoint_reg, out_pct_reg, out_temp_reg};

    // An accepted tick starts the core
    `RHBS_ASSERT_NEXT(a_accept_starts_core, s_tvalid && s_tready, core_status.busy)
    // A finished result is held while the output register is blocked
    `RHBS_ASSERT_NEXT(a_result_held, core_status.result_valid && m_tvalid && !m_tready, core_status.result_valid)
    // The applied percentage never exceeds full power
    `RHBS_ASSERT_IMPLIES(a_pct_in_range, m_tvalid, m_tdata[22:16] <= 7'd100)

endmodule

>>> hw/rtl/rhbs_mul_unit.sv
// Shared 64x64 -> 128 bit multiplier built from one 32x32 multiplier.
// Four partial products, one per cycle, accumulated into a 128 bit sum; uses rhbs_pkg.
module rhbs_mul_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic         done,
    output logic [127:0] prod
);
    import rhbs_pkg::*;

    logic         busy_reg;
    logic         done_reg;
    logic         ppv_reg;
    logic [2:0]   cnt_reg;
    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   sh_reg;
    logic [127:0] acc_reg;

    logic [31:0]  a_dig;
    logic [31:0]  b_dig;
    logic [127:0] pp_shifted;

    // Pick the operand digits for the current partial product
    assign a_dig = cnt_reg[0] ? a_reg[63:32] : a_reg[31:0];
    assign b_dig = cnt_reg[1] ? b_reg[63:32] : b_reg[31:0];

    // Align the registered partial product to its digit weight
    always_comb
    begin
        case (sh_reg)
            2'd0:    pp_shifted = {64'd0, pp_reg};
            2'd1:    pp_shifted = {32'd0, pp_reg, 32'd0};
            2'd2:    pp_shifted = {pp_reg, 64'd0};
            default: pp_shifted = '0;
        endcase
    end

    // Control: count partial products and flag completion
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ppv_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                ppv_reg  <= 1'b0;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                ppv_reg <= (cnt_reg != 3'd4);
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd4)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: operand capture, one multiply and one accumulate per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != 3'd4)
            begin
                pp_reg <= a_dig * b_dig;
                sh_reg <= {1'b0, cnt_reg[0]} + {1'b0, cnt_reg[1]};
            end
            if (ppv_reg)
            begin
                acc_reg <= acc_reg + pp_shifted;
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

>>> hw/rtl/rhbs_core.sv
// Sequencer and datapath for one Euler step of the room temperature.
// Drives the shared multiplier rhbs_mul_unit; uses rhbs_pkg.
module rhbs_core #(
    parameter int FRAC_BITS = rhbs_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [rhbs_pkg::PCT_W-1:0]    pct,
    input  logic [rhbs_pkg::CFG_W-1:0]    outside_c,
    input  logic                          result_take,
    output rhbs_pkg::core_status_t        status,
    output logic [rhbs_pkg::TEMP_W-1:0]   room_temp_c
);
    import rhbs_pkg::*;

    localparam int SW    = 12 + FRAC_BITS;
    localparam int SHIFT = 32 - FRAC_BITS;
    localparam logic [SW-1:0] STATE_RESET = SW'(RESET_Q32 >> SHIFT);

    core_state_t fsm_reg;
    core_state_t fsm_next;

    logic [SW-1:0]     temp_k_reg;
    logic [PCT_W-1:0]  pct_reg;
    logic [40:0]       to_reg;
    logic [43:0]       mag_reg;
    logic              cond_neg_reg;
    logic [29:0]       heat_reg;
    logic [55:0]       t2_reg;
    logic [63:0]       t4x_reg;
    logic [63:0]       dr_reg;
    logic              rad_neg_reg;
    logic [46:0]       rad_reg;
    logic [33:0]       cond_reg;
    logic [49:0]       sum_reg;
    logic [TEMP_W-1:0] temp_c_reg;
    logic              mul_wait_reg;

    logic              mul_start;
    logic              mul_done;
    logic [63:0]       mul_a;
    logic [63:0]       mul_b;
    logic [127:0]      mul_prod;
    logic              in_mul_state;

    logic [XW-1:0]     x;
    logic [41:0]       to_s;
    logic [45:0]       diff;
    logic [63:0]       t4o;
    logic [49:0]       cond_term;
    logic [49:0]       rad_term;
    logic [49:0]       nx;
    logic [XW-1:0]     nx_sat;
    logic [45:0]       d_c;
    logic [21:0]       q_c;

    // Current temperature as Q12.32 Kelvin
    assign x = XW'(temp_k_reg) << SHIFT;

    // Outside temperature in Q12.32 Kelvin, always positive
    assign to_s = {{3{outside_c[CFG_W-1]}}, outside_c, 24'd0} + 42'(KELVIN_Q32);
    assign diff = {2'b00, x} - {5'd0, to_reg};

    assign t4o = mul_prod[111:48];

    // Signed terms of the heat balance
    assign cond_term = cond_neg_reg ? {16'd0, cond_reg} : (50'd0 - {16'd0, cond_reg});
    assign rad_term  = rad_neg_reg ? {3'd0, rad_reg} : (50'd0 - {3'd0, rad_reg});
    assign nx        = sum_reg + rad_term;

    // Clamp the new temperature to the Kelvin range
    always_comb
    begin
        if (nx[49])
        begin
            nx_sat = '0;
        end
        else if (nx[48:44] != 5'd0)
        begin
            nx_sat = X_MAX;
        end
        else
        begin
            nx_sat = nx[43:0];
        end
    end

    // Celsius report: floor of the offset from 273.15 K, 1/256 degree
    assign d_c = {2'b00, x} - 46'(KELVIN_Q32);
    assign q_c = d_c[45:24];

    rhbs_mul_unit u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    // Next state
    always_comb
    begin
        fsm_next = fsm_reg;
        unique case (fsm_reg)
            CORE_IDLE:   if (start) fsm_next = CORE_HEAT;
            CORE_HEAT:   if (mul_done) fsm_next = CORE_SQ_X;
            CORE_SQ_X:   if (mul_done) fsm_next = CORE_QUAD_X;
            CORE_QUAD_X: if (mul_done) fsm_next = CORE_SQ_O;
            CORE_SQ_O:   if (mul_done) fsm_next = CORE_QUAD_O;
            CORE_QUAD_O: if (mul_done) fsm_next = CORE_RAD;
            CORE_RAD:    if (mul_done) fsm_next = CORE_COND;
            CORE_COND:   if (mul_done) fsm_next = CORE_SUM;
            CORE_SUM:    fsm_next = CORE_SAT;
            CORE_SAT:    fsm_next = CORE_REPORT;
            CORE_REPORT: fsm_next = CORE_DONE;
            CORE_DONE:   if (result_take) fsm_next = CORE_IDLE;
            default:     fsm_next = CORE_IDLE;
        endcase
    end

    // Outputs: multiplier operands, start strobe and status
    always_comb
    begin
        in_mul_state = 1'b1;
        mul_a        = '0;
        mul_b        = '0;
        unique case (fsm_reg)
            CORE_HEAT:
            begin
                mul_a = 64'(pct_reg);
                mul_b = CH_Q32;
            end
            CORE_SQ_X:
            begin
                mul_a = 64'(x);
                mul_b = 64'(x);
            end
            CORE_QUAD_X, CORE_QUAD_O:
            begin
                mul_a = 64'(t2_reg);
                mul_b = 64'(t2_reg);
            end
            CORE_SQ_O:
            begin
                mul_a = 64'(to_reg);
                mul_b = 64'(to_reg);
            end
            CORE_RAD:
            begin
                mul_a = dr_reg;
                mul_b = CR_Q80;
            end
            CORE_COND:
            begin
                mul_a = 64'(mag_reg);
                mul_b = C1_Q32;
            end
            default:
            begin
                in_mul_state = 1'b0;
            end
        endcase
        mul_start           = in_mul_state && !mul_wait_reg;
        status.busy         = (fsm_reg != CORE_IDLE);
        status.result_valid = (fsm_reg == CORE_DONE);
    end

    // State register, multiplier handshake and Kelvin state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg      <= CORE_IDLE;
            mul_wait_reg <= 1'b0;
            temp_k_reg   <= STATE_RESET;
        end
        else
        begin
            fsm_reg <= fsm_next;
            if (mul_start)
            begin
                mul_wait_reg <= 1'b1;
            end
            else if (mul_done)
            begin
                mul_wait_reg <= 1'b0;
            end
            if (fsm_reg == CORE_SAT)
            begin
                temp_k_reg <= SW'(nx_sat >> SHIFT);
            end
        end
    end

    // Working registers of the step
    always_ff @(posedge clk)
    begin
        case (fsm_reg)
            CORE_IDLE:
            begin
                if (start)
                begin
                    pct_reg <= pct;
                    to_reg  <= to_s[40:0];
                end
            end
            CORE_HEAT:
            begin
                // Conduction difference uses the outside value latched on start
                cond_neg_reg <= diff[45];
                mag_reg      <= diff[45] ? 44'(46'd0 - diff) : diff[43:0];
                if (mul_done)
                begin
                    heat_reg <= mul_prod[29:0];
                end
            end
            CORE_SQ_X, CORE_SQ_O:
            begin
                if (mul_done)
                begin
                    t2_reg <= mul_prod[87:32];
                end
            end
            CORE_QUAD_X:
            begin
                if (mul_done)
                begin
                    t4x_reg <= mul_prod[111:48];
                end
            end
            CORE_QUAD_O:
            begin
                if (mul_done)
                begin
                    rad_neg_reg <= (t4x_reg < t4o);
                    dr_reg      <= (t4x_reg < t4o) ? (t4o - t4x_reg) : (t4x_reg - t4o);
                end
            end
            CORE_RAD:
            begin
                if (mul_done)
                begin
                    rad_reg <= mul_prod[110:64];
                end
            end
            CORE_COND:
            begin
                if (mul_done)
                begin
                    cond_reg <= mul_prod[65:32];
                end
            end
            CORE_SUM:
            begin
                sum_reg <= {6'd0, x} + {20'd0, heat_reg} + cond_term;
            end
            CORE_REPORT:
            begin
                // Saturate the Celsius value to 16 bits
                if (!q_c[21] && (q_c[20:15] != 6'd0))
                begin
                    temp_c_reg <= 16'h7FFF;
                end
                else if (q_c[21] && (q_c[20:15] != 6'h3F))
                begin
                    temp_c_reg <= 16'h8000;
                end
                else
                begin
                    temp_c_reg <= q_c[15:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    assign room_temp_c = temp_c_reg;

endmodule
